### rtl/ir_packet_deframer_xor_check_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the IR packet deframer
// Implication and next-cycle checks on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef IR_PACKET_DEFRAMER_XOR_CHECK_ASSERT_SVH
`define IR_PACKET_DEFRAMER_XOR_CHECK_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define IPDX_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ipdx assertion failed");

// next-cycle implication
`define IPDX_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ipdx assertion failed");

`else

`define IPDX_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define IPDX_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### rtl/ipdx_pkg.sv
// ----------------------------------------------------------------------------
// ipdx_pkg
// Shared constants and types of the IR packet deframer.
// ----------------------------------------------------------------------------
package ipdx_pkg;

    localparam int DEF_BUFFER_DEPTH = 64;

    localparam logic [7:0] START_MARK = 8'h23;  // '#'
    localparam logic [7:0] END_MARK   = 8'h25;  // '%'
    localparam logic [3:0] NIBBLE_MASK = 4'hf;

    typedef enum logic [1:0] {
        STAT_GOOD     = 2'd0,
        STAT_OVERRUN  = 2'd1,
        STAT_BAD_ID   = 2'd2,
        STAT_BAD_SUM  = 2'd3
    } t_status;

endpackage

### rtl/ipdx_if.sv
// ----------------------------------------------------------------------------
// ipdx channel interfaces
// Valid/ready channels for received bytes and for result items.
// ----------------------------------------------------------------------------
interface ipdx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ipdx_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last;

    modport source (output valid, output status, output payload_byte,
                    output byte_valid, output last, input ready);
    modport sink   (input valid, input status, input payload_byte,
                    input byte_valid, input last, output ready);
endinterface

### rtl/ipdx_buf.sv
// ----------------------------------------------------------------------------
// ipdx_buf
// Packet byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ipdx_buf
    import ipdx_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    localparam int AW = $clog2(BUFFER_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [BUFFER_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ir_packet_deframer_xor_check.sv
// ----------------------------------------------------------------------------
// ir_packet_deframer_xor_check
// Deframes '#'...'%' packets, checks sender id and split-nibble XOR checksum,
// then sends a status item or the payload bytes of a good packet.
//
//   channel   dir  handshake     payload
//   i_in      in   valid/ready   rx_byte[7:0]
//   o_out     out  valid/ready   status[1:0], payload_byte[7:0], byte_valid, last
//   i_cfg     in   write enable  i_cfg_data[7:0] -> expected sender id
//
// Receiving: one byte per cycle while idle; the checks are kept as running
// values (first byte, XOR, last two bytes), so the closing '%' is taken like
// any other byte. A good packet then holds the input while the single read
// port of the byte store streams the payload, a byte per cycle unless stalled.
// Reset is synchronous and clears control state only; the store is not cleared.
// A full output register stalls the drain and blocks only a closing '%'.
// ----------------------------------------------------------------------------
`include "ir_packet_deframer_xor_check_assert.svh"

module ir_packet_deframer_xor_check
    import ipdx_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ipdx_in_if.sink           i_in,
    ipdx_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    // control state
    t_state        r_state, n_state;
    logic [AW-1:0] r_fill, n_fill;
    logic          r_inside, n_inside;
    logic          r_overrun, n_overrun;
    logic          r_issuing, n_issuing;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [AW-1:0] r_rd_end, n_rd_end;
    logic          r_q_valid, n_q_valid;
    logic          r_q_last, n_q_last;
    logic          r_ov, n_ov;
    logic [7:0]    r_sender_id;

    // payload state
    logic [7:0]    r_first, r_xor, r_b1, r_b2;
    t_status       r_status, n_status;
    logic [7:0]    r_pbyte, n_pbyte;
    logic          r_bvalid, n_bvalid;
    logic          r_last, n_last;

    logic [7:0]    c;
    logic          in_fire, is_start, is_end, is_data, full;
    logic          wr_en, do_close, out_free, q_move, rd_issue;
    logic [7:0]    sum, ref_sum;
    t_status       verdict;
    logic [7:0]    q_data;

    assign c        = i_in.rx_byte;
    assign is_start = (c == START_MARK);
    assign is_end   = (c == END_MARK);
    assign is_data  = (c != 8'd0) && !is_start && !is_end;
    assign full     = (r_fill == AW'(BUFFER_DEPTH - 1));

    assign out_free = !r_ov || o_out.ready;
    assign q_move   = r_q_valid && out_free;
    assign rd_issue = r_issuing && (!r_q_valid || q_move);

    // only a closing byte needs the output register
    assign i_in.ready = (r_state == ST_IDLE) && (out_free || !is_end);
    assign in_fire    = i_in.valid && i_in.ready;

    assign wr_en    = in_fire && r_inside && is_data && !full;
    assign do_close = in_fire && r_inside && is_end;

    // running XOR covers bytes 1..L-1; strip the two checksum bytes
    assign sum     = r_xor ^ r_b1 ^ r_b2;
    assign ref_sum = {r_b1[3:0] & NIBBLE_MASK, r_b2[3:0] & NIBBLE_MASK};

    always_comb begin
        if (r_overrun) begin
            verdict = STAT_OVERRUN;
        end else if (r_fill == '0 || r_first != r_sender_id) begin
            verdict = STAT_BAD_ID;
        end else if (r_fill < AW'(3) || sum != ref_sum) begin
            verdict = STAT_BAD_SUM;
        end else begin
            verdict = STAT_GOOD;
        end
    end

    // no write can hit the store while it drains: input is held in ST_DRAIN
    ipdx_buf #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_fill),
        .i_wdata (c),
        .i_re    (rd_issue),
        .i_raddr (r_rd_idx),
        .o_rdata (q_data)
    );

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_inside  = r_inside;
        n_overrun = r_overrun;
        n_issuing = r_issuing;
        n_rd_idx  = r_rd_idx;
        n_rd_end  = r_rd_end;
        n_q_valid = r_q_valid;
        n_q_last  = r_q_last;
        n_ov      = r_ov;
        n_status  = r_status;
        n_pbyte   = r_pbyte;
        n_bvalid  = r_bvalid;
        n_last    = r_last;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (is_start) begin
                        n_fill    = '0;
                        n_overrun = 1'b0;
                        n_inside  = 1'b1;
                    end else if (r_inside && is_end) begin
                        n_fill    = '0;
                        n_overrun = 1'b0;
                        n_inside  = 1'b0;
                        if (verdict == STAT_GOOD && r_fill != AW'(3)) begin
                            n_state   = ST_DRAIN;
                            n_issuing = 1'b1;
                            n_rd_idx  = AW'(1);
                            n_rd_end  = r_fill - AW'(3);
                        end else begin
                            n_ov     = 1'b1;
                            n_status = verdict;
                            n_pbyte  = 8'd0;
                            n_bvalid = 1'b0;
                            n_last   = 1'b1;
                        end
                    end else if (r_inside && is_data) begin
                        if (full) begin
                            n_overrun = 1'b1;
                        end else begin
                            n_fill = r_fill + AW'(1);
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (rd_issue) begin
                    n_q_last = (r_rd_idx == r_rd_end);
                    if (r_rd_idx == r_rd_end) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_rd_idx = r_rd_idx + AW'(1);
                    end
                end
                n_q_valid = rd_issue || (r_q_valid && !q_move);
                if (q_move) begin
                    n_ov     = 1'b1;
                    n_status = STAT_GOOD;
                    n_pbyte  = q_data;
                    n_bvalid = 1'b1;
                    n_last   = r_q_last;
                    if (r_q_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_inside    <= 1'b0;
            r_overrun   <= 1'b0;
            r_issuing   <= 1'b0;
            r_rd_idx    <= '0;
            r_rd_end    <= '0;
            r_q_valid   <= 1'b0;
            r_q_last    <= 1'b0;
            r_ov        <= 1'b0;
            r_sender_id <= 8'd0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_inside  <= n_inside;
            r_overrun <= n_overrun;
            r_issuing <= n_issuing;
            r_rd_idx  <= n_rd_idx;
            r_rd_end  <= n_rd_end;
            r_q_valid <= n_q_valid;
            r_q_last  <= n_q_last;
            r_ov      <= n_ov;
            if (i_cfg_we) begin
                r_sender_id <= i_cfg_data;
            end
        end
    end

    // output item registers, and the check summary tracked as bytes are stored
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_pbyte  <= n_pbyte;
        r_bvalid <= n_bvalid;
        r_last   <= n_last;
        if (wr_en) begin
            r_b2 <= r_b1;
            r_b1 <= c;
            if (r_fill == '0) begin
                r_first <= c;
                r_xor   <= 8'd0;
            end else begin
                r_xor <= r_xor ^ c;
            end
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.status       = r_status;
    assign o_out.payload_byte = r_pbyte;
    assign o_out.byte_valid   = r_bvalid;
    assign o_out.last         = r_last;

    // the next payload byte is already queued when a non-last one is taken
    `IPDX_ASSERT_IMP(a_no_write_in_drain, i_clk, i_rst_n, r_state == ST_DRAIN, !wr_en)
    `IPDX_ASSERT_IMP(a_last_read_ends_issue, i_clk, i_rst_n, r_q_valid && r_q_last, !r_issuing)
    `IPDX_ASSERT_NXT(a_more_after_nonlast, i_clk, i_rst_n, o_out.valid && o_out.ready && !o_out.last, o_out.valid)
    `IPDX_ASSERT_IMP(a_empty_reg_no_stall, i_clk, i_rst_n, r_state == ST_IDLE && !r_ov, i_in.ready)

endmodule

### tb/ir_packet_deframer_xor_check_tb.sv
// ----------------------------------------------------------------------------
// ir_packet_deframer_xor_check_tb
// Self-checking bench for the '#'...'%' deframer. Bytes go in over the input
// channel with random gaps. A scoreboard predicts the status or payload items
// of every closed frame, and each transfer on the output channel is compared
// with the oldest prediction. The sender id is changed between phases, only
// while the block is idle.
// ----------------------------------------------------------------------------
import ipdx_pkg::*;

typedef struct {
    t_status    status;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last;
} t_frame_out;

class t_frame_checker;
    logic [7:0]  sender_id;
    logic [7:0]  frame_store [DEF_BUFFER_DEPTH];
    int unsigned fill_count;
    bit          in_frame;
    bit          overrun_seen;
    t_frame_out  pending_items [$];
    int unsigned mismatches;

    function new();
        sender_id    = 8'h00;
        fill_count   = 0;
        in_frame     = 1'b0;
        overrun_seen = 1'b0;
        mismatches   = 0;
    endfunction

    function void push_item(t_status st, logic [7:0] b, logic v, logic l);
        t_frame_out item;
        item.status       = st;
        item.payload_byte = b;
        item.byte_valid   = v;
        item.last         = l;
        pending_items.push_back(item);
    endfunction

    function void close_frame();
        logic [7:0]  csum;
        logic [7:0]  trailer;
        int unsigned i;
        if (overrun_seen) begin
            push_item(STAT_OVERRUN, 8'h00, 1'b0, 1'b1);
        end else if (fill_count == 0 || frame_store[0] != sender_id) begin
            push_item(STAT_BAD_ID, 8'h00, 1'b0, 1'b1);
        end else if (fill_count < 3) begin
            push_item(STAT_BAD_SUM, 8'h00, 1'b0, 1'b1);
        end else begin
            csum = 8'h00;
            for (i = 1; i + 2 < fill_count; i++)
                csum ^= frame_store[i];
            // high nibble rides in the low nibble of the final byte
            trailer = {frame_store[fill_count-1][3:0], frame_store[fill_count-2][3:0]};
            if (trailer != csum) begin
                push_item(STAT_BAD_SUM, 8'h00, 1'b0, 1'b1);
            end else if (fill_count == 3) begin
                push_item(STAT_GOOD, 8'h00, 1'b0, 1'b1);
            end else begin
                for (i = 1; i + 2 < fill_count; i++)
                    push_item(STAT_GOOD, frame_store[i], 1'b1, (i + 3 == fill_count));
            end
        end
    endfunction

    function void take_byte(logic [7:0] c);
        if (c == 8'h00)
            return;
        if (c == START_MARK) begin
            fill_count   = 0;
            overrun_seen = 1'b0;
            in_frame     = 1'b1;
            return;
        end
        if (!in_frame)
            return;
        if (c == END_MARK) begin
            close_frame();
            fill_count   = 0;
            overrun_seen = 1'b0;
            in_frame     = 1'b0;
            return;
        end
        if (fill_count + 1 >= DEF_BUFFER_DEPTH) begin
            overrun_seen = 1'b1;
            return;
        end
        frame_store[fill_count] = c;
        fill_count++;
    endfunction

    function void note_mismatch(string msg);
        if (mismatches < 10)
            $display("mismatch: %s", msg);
        mismatches++;
    endfunction

    function void check_item(logic [1:0] st, logic [7:0] b, logic v, logic l);
        t_frame_out want;
        if (pending_items.size() == 0) begin
            note_mismatch($sformatf("unexpected item status=%0d byte=%02h valid=%0b last=%0b",
                                    st, b, v, l));
            return;
        end
        want = pending_items.pop_front();
        if (st !== want.status || b !== want.payload_byte ||
            v !== want.byte_valid || l !== want.last)
            note_mismatch($sformatf(
                "expected status=%0d byte=%02h valid=%0b last=%0b, got %0d %02h %0b %0b",
                want.status, want.payload_byte, want.byte_valid, want.last, st, b, v, l));
    endfunction
endclass

module ir_packet_deframer_xor_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RUN_LIMIT     = 1000000;
    localparam int PHASE_ITEMS   = 20;

    localparam int FORCE_NONE    = 0;
    localparam int FORCE_LONG    = 1;
    localparam int FORCE_OVERRUN = 2;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [7:0] cfg_data;

    ipdx_in_if  in_if ();
    ipdx_out_if out_if ();

    t_frame_checker sb = new();

    logic [7:0]  tx_bytes [$];
    bit          no_idle;
    bit          hold_out_pending;
    int unsigned quiet_cycles;
    int unsigned run_cycles;

    ir_packet_deframer_xor_check u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 10);
    endfunction

    // any byte that is stored as frame data: not zero, not a delimiter
    function automatic logic [7:0] data_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b == START_MARK || b == END_MARK);
        return b;
    endfunction

    function automatic logic [7:0] nibble_byte(logic [3:0] nib);
        logic [7:0] b;
        do b = {4'($urandom_range(0, 15)), nib};
        while (b == 8'h00 || b == START_MARK || b == END_MARK);
        return b;
    endfunction

    function automatic void push_data(logic [7:0] b);
        if ($urandom_range(0, 15) == 0)
            tx_bytes.push_back(8'h00);
        tx_bytes.push_back(b);
    endfunction

    function automatic void build_good(logic [7:0] id, int plen, bit corrupt);
        logic [7:0] csum;
        logic [7:0] b;
        logic [3:0] flip;
        csum = 8'h00;
        tx_bytes.push_back(START_MARK);
        push_data(id);
        for (int i = 0; i < plen; i++) begin
            b = data_byte();
            csum ^= b;
            push_data(b);
        end
        flip = corrupt ? 4'($urandom_range(1, 15)) : 4'h0;
        push_data(nibble_byte(csum[3:0] ^ flip));
        push_data(nibble_byte(csum[7:4]));
        tx_bytes.push_back(END_MARK);
    endfunction

    function automatic void build_overrun(logic [7:0] id);
        int n;
        n = $urandom_range(DEF_BUFFER_DEPTH, DEF_BUFFER_DEPTH + 6);
        tx_bytes.push_back(START_MARK);
        push_data(id);
        for (int i = 1; i < n; i++)
            push_data(data_byte());
        tx_bytes.push_back(END_MARK);
    endfunction

    function automatic void build_random(logic [7:0] id);
        int kind;
        int plen;
        logic [7:0] bad_id;
        kind = $urandom_range(0, 99);
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 60) : $urandom_range(0, 8);
        if (kind < 55) begin
            build_good(id, plen, 1'b0);
        end else if (kind < 65) begin
            build_good(id, plen, 1'b1);
        end else if (kind < 73) begin
            do bad_id = data_byte();
            while (bad_id == id);
            build_good(bad_id, plen, 1'b0);
        end else if (kind < 76) begin
            build_overrun(id);
        end else if (kind < 84) begin
            tx_bytes.push_back(START_MARK);
            push_data(id);
            if ($urandom_range(0, 1))
                push_data(data_byte());
            tx_bytes.push_back(END_MARK);
        end else if (kind < 90) begin
            // abandoned frame, restarted by a fresh start mark
            tx_bytes.push_back(START_MARK);
            for (int i = $urandom_range(0, 5); i > 0; i--)
                push_data(data_byte());
            build_good(id, plen, 1'b0);
        end else begin
            for (int i = $urandom_range(1, 6); i > 0; i--)
                tx_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // called right after a rising edge; returns at the edge of the transfer
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.rx_byte <= b;
        do @(posedge i_clk);
        while (!in_if.ready);
        sb.take_byte(b);
    endtask

    task automatic send_queued(inout int sent);
        logic [7:0] b;
        while (tx_bytes.size() != 0) begin
            b = tx_bytes.pop_front();
            if (b != 8'h00)
                sent++;
            send_byte(b);
        end
    endtask

    task automatic write_sender_id(input logic [7:0] id);
        cfg_we   <= 1'b1;
        cfg_data <= id;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        sb.sender_id = id;
    endtask

    // close any open frame so the id never changes mid-frame, then go idle
    task automatic drain_block();
        if (sb.in_frame)
            send_byte(END_MARK);
        in_if.valid <= 1'b0;
        while (sb.pending_items.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [7:0] id, input int force_kind);
        int sent;
        sent = 0;
        write_sender_id(id);
        if (force_kind == FORCE_LONG)
            build_good(id, DEF_BUFFER_DEPTH - 4, 1'b0);
        else if (force_kind == FORCE_OVERRUN)
            build_overrun(id);
        send_queued(sent);
        while (sent < PHASE_ITEMS) begin
            build_random(id);
            send_queued(sent);
        end
        drain_block();
    endtask

    // result side: per-item stall, or one long hold-off on request
    initial begin
        int gap;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_out_pending) begin
                gap = HOLD_CYCLES;
                hold_out_pending = 1'b0;
            end else begin
                gap = draw_gap();
            end
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk);
            while (!out_if.valid);
            sb.check_item(out_if.status, out_if.payload_byte, out_if.byte_valid, out_if.last);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            run_cycles++;
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT || run_cycles >= RUN_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] rand_id;
        int         sent;
        quiet_cycles     = 0;
        run_cycles       = 0;
        no_idle          = 1'b0;
        hold_out_pending = 1'b0;
        sent             = 0;
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_data      <= 8'h00;
        in_if.valid   <= 1'b0;
        in_if.rx_byte <= 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: ignored zero, stray bytes, empty, short, restart,
        // good with no payload, good with payload extremes, bad checksum
        write_sender_id(8'h5A);
        tx_bytes = '{8'h00, 8'h41, END_MARK,
                     START_MARK, END_MARK,
                     START_MARK, 8'h5A, 8'h11, END_MARK,
                     START_MARK, 8'h5A, START_MARK, 8'h5A, 8'h40, 8'h80, END_MARK,
                     START_MARK, 8'h5A, 8'h01, 8'hFF, 8'h0E, 8'h0F, END_MARK,
                     START_MARK, 8'h5A, 8'h33, 8'h01, 8'h01, END_MARK};
        send_queued(sent);
        drain_block();

        run_phase(8'hFF, FORCE_LONG);
        run_phase(8'h01, FORCE_OVERRUN);
        no_idle = 1'b1;
        run_phase(8'h00, FORCE_NONE);
        no_idle = 1'b0;
        do rand_id = 8'($urandom_range(1, 255));
        while (rand_id == START_MARK || rand_id == END_MARK);
        hold_out_pending = 1'b1;
        run_phase(rand_id, FORCE_NONE);
        run_phase(8'($urandom_range(0, 255)), FORCE_NONE);

        if (sb.mismatches == 0 && sb.pending_items.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/ipdx_pkg.sv
rtl/ipdx_if.sv
rtl/ipdx_buf.sv
rtl/ir_packet_deframer_xor_check.sv
tb/ir_packet_deframer_xor_check_tb.sv
